// ----- rtl/idm_pkg.sv -----
// shared widths, types and register indexes of the image difference metric
package idm_pkg;

   localparam int PIX_W      = 8;
   localparam int WGT_W      = 12;
   localparam int POS_W      = 12;
   localparam int DIM_W      = 13;
   localparam int PROD_W     = 20;
   localparam int SQ_W       = 40;
   localparam int TERM_W     = 42;
   localparam int SUM_W      = 62;
   localparam int NUM_LANES  = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;
   localparam int MAX_DIM_DEFAULT = 4096;

   localparam logic [WGT_W-1:0] WEIGHT_ONE  = 12'd256;
   localparam logic [DIM_W-1:0] WIN_DIM_RST = 13'd4096;
   localparam logic [SUM_W-1:0] SUM_CEIL    = {SUM_W{1'b1}};

   localparam logic [CSR_IDX_W-1:0] CSR_MODE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIN_X     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WIN_Y     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WIN_W     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WIN_H     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_C0 = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_C1 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_C2 = 3'd7;

   localparam logic MODE_MONO = 1'b0;
   localparam logic MODE_RGB  = 1'b1;

   typedef logic [PIX_W-1:0]  pix_type;
   typedef logic [WGT_W-1:0]  wgt_type;
   typedef logic [SQ_W-1:0]   sq_type;
   typedef logic [TERM_W-1:0] term_type;
   typedef logic [SUM_W-1:0]  sum_type;

   typedef struct packed {
      logic vld;
      logic eof;
   } stage_ctl_type;

endpackage

// ----- rtl/idm_if.sv -----
// pixel pair and result channel interfaces
interface idm_req_if;
   import idm_pkg::*;

   logic    valid;
   logic    ready;
   pix_type a_c0;
   pix_type a_c1;
   pix_type a_c2;
   pix_type b_c0;
   pix_type b_c1;
   pix_type b_c2;
   logic    end_of_row;
   logic    end_of_frame;

   modport source (output valid, a_c0, a_c1, a_c2, b_c0, b_c1, b_c2, end_of_row,
                   end_of_frame, input ready);
   modport sink   (input valid, a_c0, a_c1, a_c2, b_c0, b_c1, b_c2, end_of_row,
                   end_of_frame, output ready);
endinterface

interface idm_rsp_if;
   import idm_pkg::*;

   logic     valid;
   logic     ready;
   sum_type  total_error;
   term_type max_term;
   logic     saturated;

   modport source (output valid, total_error, max_term, saturated, input ready);
   modport sink   (input valid, total_error, max_term, saturated, output ready);
endinterface

// ----- rtl/idm_lane.sv -----
// one channel lane: weighted absolute difference, then its square
module idm_lane (
   input  logic              clock,
   input  logic              advance,
   input  idm_pkg::pix_type  a,
   input  idm_pkg::pix_type  b,
   input  idm_pkg::wgt_type  w,
   output idm_pkg::sq_type   sq
);
   import idm_pkg::*;

   logic [PIX_W-1:0]  diff;
   logic [PROD_W-1:0] prod_in, prod_ff;
   sq_type            sq_in, sq_ff;

   always_comb begin
      diff    = (a >= b) ? (a - b) : (b - a);
      prod_in = PROD_W'(diff) * PROD_W'(w);
      sq_in   = SQ_W'(prod_ff) * SQ_W'(prod_ff);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         sq_ff   <= sq_in;
      end
   end

   assign sq = sq_ff;

endmodule

// ----- rtl/idm_merge.sv -----
// adds the lane squares into one pixel term
module idm_merge (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  idm_pkg::stage_ctl_type ctl,
   input  idm_pkg::sq_type       sq [idm_pkg::NUM_LANES],
   output idm_pkg::stage_ctl_type term_ctl,
   output idm_pkg::term_type     term
);
   import idm_pkg::*;

   term_type      term_in, term_ff;
   stage_ctl_type ctl_ff;

   always_comb begin
      term_in = '0;
      for (int i = 0; i < NUM_LANES; i++) begin
         term_in = term_in + TERM_W'(sq[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         term_ff <= term_in;
      end
   end

   assign term_ctl = ctl_ff;
   assign term     = term_ff;

endmodule

// ----- rtl/idm_accum.sv -----
// saturating frame total, running maximum and the result register
module idm_accum (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  idm_pkg::stage_ctl_type ctl,
   input  idm_pkg::term_type      term,
   input  logic                   out_ready,
   output logic                   out_valid,
   output idm_pkg::sum_type       out_total,
   output idm_pkg::term_type      out_max,
   output logic                   out_sat
);
   import idm_pkg::*;

   sum_type        sum_ff, sum_in;
   term_type       max_ff, max_in;
   logic           sat_ff, sat_in;
   logic           valid_ff, valid_in;
   sum_type        total_ff;
   term_type       maxo_ff;
   logic           sato_ff;
   logic [SUM_W:0] sum_wide;

   always_comb begin
      sum_wide = {1'b0, sum_ff} + (SUM_W + 1)'(term);
      if (sum_wide >= (SUM_W + 1)'(SUM_CEIL)) begin
         sum_in = SUM_CEIL;
         sat_in = 1'b1;
      end else begin
         sum_in = sum_wide[SUM_W-1:0];
         sat_in = sat_ff;
      end
      max_in   = (term > max_ff) ? term : max_ff;
      valid_in = valid_ff && !out_ready;
      if (advance) begin
         valid_in = ctl.vld && ctl.eof;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         max_ff   <= '0;
         sat_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (advance && ctl.vld) begin
            if (ctl.eof) begin
               sum_ff <= '0;
               max_ff <= '0;
               sat_ff <= 1'b0;
            end else begin
               sum_ff <= sum_in;
               max_ff <= max_in;
               sat_ff <= sat_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && ctl.vld && ctl.eof) begin
         total_ff <= sum_in;
         maxo_ff  <= max_in;
         sato_ff  <= sat_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_total = total_ff;
   assign out_max   = maxo_ff;
   assign out_sat   = sato_ff;

endmodule

// ----- rtl/image_difference_metric.sv -----
// top level of the streaming image difference metric
// takes one pixel pair per clock and keeps that rate while the result channel
// accepts; a result beat appears after the beat carrying end_of_frame has passed
// through four register stages: channel difference times weight, the square in
// each of three parallel lanes, the merge adder that forms the pixel term, and
// the saturating accumulator with its result register. the whole pipeline
// holds only while a finished result waits unaccepted at the output. a pixel
// counts when its column and row fall inside the configured window; mono mode uses
// lane zero with a weight of 1.0, rgb mode all three lanes with their configured
// weights. configuration must be written when the block is idle (not enforced).
module image_difference_metric #(
   parameter int MAX_DIM = idm_pkg::MAX_DIM_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   idm_req_if.sink                         req_bus,
   idm_rsp_if.source                       rsp_bus,
   input  logic                            csr_we,
   input  logic [idm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [idm_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import idm_pkg::*;

   localparam int CW    = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
   localparam int CMP_W = ((CW > DIM_W) ? CW : DIM_W) + 1;
   localparam logic [CW-1:0] POS_LAST = CW'(MAX_DIM - 1);

   // configuration registers
   logic             mode_ff;
   logic [POS_W-1:0] win_x_ff, win_y_ff;
   logic [DIM_W-1:0] win_w_ff, win_h_ff;
   wgt_type          weight_ff [NUM_LANES];

   // raster position of the next pixel
   logic [CW-1:0]    col_ff, col_in, row_ff, row_in;

   logic             advance;
   logic             accept;
   logic             in_x, in_y, in_win;
   logic [CMP_W-1:0] col_ext, row_ext;

   pix_type          lane_a [NUM_LANES];
   pix_type          lane_b [NUM_LANES];
   wgt_type          lane_w [NUM_LANES];
   sq_type           lane_sq [NUM_LANES];

   stage_ctl_type    s1_ff, s1_in, s2_ff, s3_ctl;
   term_type         s3_term;

   // whole pipeline moves unless a result beat is stuck at the output
   assign advance       = !rsp_bus.valid || rsp_bus.ready;
   assign req_bus.ready = advance;
   assign accept        = req_bus.valid && advance;

   // config write port
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_MONO;
         win_x_ff  <= '0;
         win_y_ff  <= '0;
         win_w_ff  <= WIN_DIM_RST;
         win_h_ff  <= WIN_DIM_RST;
         for (int i = 0; i < NUM_LANES; i++) begin
            weight_ff[i] <= WEIGHT_ONE;
         end
      end else if (csr_we) begin
         case (csr_index)
            CSR_MODE:      mode_ff      <= csr_wdata[0];
            CSR_WIN_X:     win_x_ff     <= csr_wdata[POS_W-1:0];
            CSR_WIN_Y:     win_y_ff     <= csr_wdata[POS_W-1:0];
            CSR_WIN_W:     win_w_ff     <= csr_wdata[DIM_W-1:0];
            CSR_WIN_H:     win_h_ff     <= csr_wdata[DIM_W-1:0];
            CSR_WEIGHT_C0: weight_ff[0] <= csr_wdata[WGT_W-1:0];
            CSR_WEIGHT_C1: weight_ff[1] <= csr_wdata[WGT_W-1:0];
            CSR_WEIGHT_C2: weight_ff[2] <= csr_wdata[WGT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // window test on the position of the incoming pixel
   always_comb begin
      col_ext = CMP_W'(col_ff);
      row_ext = CMP_W'(row_ff);
      in_x    = (col_ext >= CMP_W'(win_x_ff)) &&
                (col_ext <  CMP_W'(win_x_ff) + CMP_W'(win_w_ff));
      in_y    = (row_ext >= CMP_W'(win_y_ff)) &&
                (row_ext <  CMP_W'(win_y_ff) + CMP_W'(win_h_ff));
      in_win  = in_x && in_y;
   end

   // position counters, both stop at the last position of the image
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (req_bus.end_of_frame) begin
         col_in = '0;
         row_in = '0;
      end else if (req_bus.end_of_row) begin
         col_in = '0;
         if (row_ff < POS_LAST) begin
            row_in = row_ff + 1'b1;
         end
      end else if (col_ff < POS_LAST) begin
         col_in = col_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // lane operands; a zero weight turns the pixel into a zero term,
   // which leaves total, maximum and flag untouched
   always_comb begin
      lane_a[0] = req_bus.a_c0;
      lane_a[1] = req_bus.a_c1;
      lane_a[2] = req_bus.a_c2;
      lane_b[0] = req_bus.b_c0;
      lane_b[1] = req_bus.b_c1;
      lane_b[2] = req_bus.b_c2;
      for (int i = 0; i < NUM_LANES; i++) begin
         if (!in_win) begin
            lane_w[i] = '0;
         end else if (mode_ff == MODE_RGB) begin
            lane_w[i] = weight_ff[i];
         end else begin
            // mono: d*d*65536 is (256*d)^2 in lane zero
            lane_w[i] = (i == 0) ? WEIGHT_ONE : '0;
         end
      end
   end

   genvar g;
   generate
      for (g = 0; g < NUM_LANES; g++) begin : g_lane
         idm_lane u_lane (
            .clock   (clock),
            .advance (advance),
            .a       (lane_a[g]),
            .b       (lane_b[g]),
            .w       (lane_w[g]),
            .sq      (lane_sq[g])
         );
      end
   endgenerate

   // beat tracking alongside the two lane stages
   always_comb begin
      s1_in.vld = accept;
      s1_in.eof = req_bus.end_of_frame;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
         s2_ff <= '0;
      end else if (advance) begin
         s1_ff <= s1_in;
         s2_ff <= s1_ff;
      end
   end

   idm_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .ctl      (s2_ff),
      .sq       (lane_sq),
      .term_ctl (s3_ctl),
      .term     (s3_term)
   );

   idm_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .ctl       (s3_ctl),
      .term      (s3_term),
      .out_ready (rsp_bus.ready),
      .out_valid (rsp_bus.valid),
      .out_total (rsp_bus.total_error),
      .out_max   (rsp_bus.max_term),
      .out_sat   (rsp_bus.saturated)
   );

`ifndef SYNTHESIS
   // a saturated total reports the ceiling
   a_sat_ceiling: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.saturated |-> rsp_bus.total_error == SUM_CEIL)
      else $error("saturated result without ceiling total");

   // the largest term never exceeds the frame total
   a_max_le_total: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> SUM_W'(rsp_bus.max_term) <= rsp_bus.total_error)
      else $error("max term above total");

   // frame end returns the raster position to the origin
   a_eof_clears_pos: assert property (@(posedge clock) disable iff (reset)
      accept && req_bus.end_of_frame |=> col_ff == '0 && row_ff == '0)
      else $error("position not cleared after frame end");

   // a plain pixel steps the column by one until the last position
   a_col_step: assert property (@(posedge clock) disable iff (reset)
      accept && !req_bus.end_of_frame && !req_bus.end_of_row && col_ff < POS_LAST
      |=> col_ff == $past(col_ff) + 1'b1)
      else $error("column count did not advance");
`endif

endmodule

// ----- verif/image_difference_metric_tb.sv -----
`timescale 1ns / 100ps
// self-checking testbench: random and directed pixel streams against a frame error predictor
module image_difference_metric_tb;
   import idm_pkg::*;

   localparam int HALF_PERIOD  = 10;
   localparam int RESET_CYCLES = 3;
   // drain time over the four register stages, with margin
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 300;
   localparam int IDLE_LIMIT   = 3000;
   localparam int RANDOM_BEATS = 1700;
   localparam int FRAME_DIM    = MAX_DIM_DEFAULT;

   // one pixel pair as offered on the request channel
   typedef struct {
      pix_type a_c0, a_c1, a_c2;
      pix_type b_c0, b_c1, b_c2;
      logic    end_of_row;
      logic    end_of_frame;
   } pixel_pair_type;

   // one frame result as expected on the response channel
   typedef struct {
      sum_type  total_error;
      term_type max_term;
      logic     saturated;
   } frame_result_type;

   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_kind_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   idm_req_if req_if ();
   idm_rsp_if rsp_if ();

   image_difference_metric u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_if),
      .rsp_bus   (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow copy of the configuration registers
   logic             cfg_mode;
   logic [POS_W-1:0] cfg_win_x;
   logic [POS_W-1:0] cfg_win_y;
   logic [DIM_W-1:0] cfg_win_w;
   logic [DIM_W-1:0] cfg_win_h;
   wgt_type          cfg_weight [NUM_LANES];

   // shadow raster position and running frame totals
   logic [POS_W-1:0] pos_col;
   logic [POS_W-1:0] pos_row;
   sum_type          sum_run;
   term_type         max_run;
   logic             sat_run;

   // frame results still owed by the block, oldest first
   frame_result_type frame_results_q [$];

   int             fail_count    = 0;
   int             beats_sent    = 0;
   int             burst_left    = 0;
   bit             sender_steady = 0;
   stall_kind_type stall_kind    = STALL_NONE;
   int             hold_requests = 0;
   int             hold_served   = 0;
   int             hold_left     = 0;
   int unsigned    stall_tick    = 0;
   int             idle_cycles   = 0;

   // free running clock
   always #HALF_PERIOD clock = ~clock;

   // ---------------------------------------------------------------
   // frame error predictor
   // ---------------------------------------------------------------

   function automatic void clear_frame_totals();
      pos_col = '0;
      pos_row = '0;
      sum_run = '0;
      max_run = '0;
      sat_run = 1'b0;
   endfunction

   // register values after reset
   function automatic void reset_shadow();
      cfg_mode  = MODE_MONO;
      cfg_win_x = '0;
      cfg_win_y = '0;
      cfg_win_w = WIN_DIM_RST;
      cfg_win_h = WIN_DIM_RST;
      for (int i = 0; i < NUM_LANES; i++)
         cfg_weight[i] = WEIGHT_ONE;
      clear_frame_totals();
   endfunction

   // a register write keeps only the low bits of its own width
   function automatic void apply_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_MODE:      cfg_mode      = data[0];
         CSR_WIN_X:     cfg_win_x     = data[POS_W-1:0];
         CSR_WIN_Y:     cfg_win_y     = data[POS_W-1:0];
         CSR_WIN_W:     cfg_win_w     = data[DIM_W-1:0];
         CSR_WIN_H:     cfg_win_h     = data[DIM_W-1:0];
         CSR_WEIGHT_C0: cfg_weight[0] = data[WGT_W-1:0];
         CSR_WEIGHT_C1: cfg_weight[1] = data[WGT_W-1:0];
         CSR_WEIGHT_C2: cfg_weight[2] = data[WGT_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic pix_type byte_distance(pix_type a, pix_type b);
      return (a >= b) ? a - b : b - a;
   endfunction

   // (difference times weight) squared for one channel
   function automatic sq_type lane_square(pix_type a, pix_type b, wgt_type w);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(byte_distance(a, b)) * PROD_W'(w);
      return SQ_W'(prod) * SQ_W'(prod);
   endfunction

   function automatic term_type pixel_term(pixel_pair_type p);
      term_type d;
      if (cfg_mode == MODE_MONO) begin
         // weight fixed at 1.0, i.e. 256 squared
         d = TERM_W'(byte_distance(p.a_c0, p.b_c0));
         return (d * d) << 16;
      end
      return TERM_W'(lane_square(p.a_c0, p.b_c0, cfg_weight[0]))
           + TERM_W'(lane_square(p.a_c1, p.b_c1, cfg_weight[1]))
           + TERM_W'(lane_square(p.a_c2, p.b_c2, cfg_weight[2]));
   endfunction

   // fold one accepted beat into the frame totals; frame end queues a result
   function automatic void accumulate_beat(pixel_pair_type p);
      int unsigned      col_end;
      int unsigned      row_end;
      term_type         term;
      logic [SUM_W:0]   trial;
      frame_result_type res;
      col_end = 32'(cfg_win_x) + 32'(cfg_win_w);
      row_end = 32'(cfg_win_y) + 32'(cfg_win_h);
      if (pos_col >= cfg_win_x && 32'(pos_col) < col_end &&
          pos_row >= cfg_win_y && 32'(pos_row) < row_end) begin
         term = pixel_term(p);
         if (term > max_run)
            max_run = term;
         trial = {1'b0, sum_run} + (SUM_W+1)'(term);
         if (trial >= {1'b0, SUM_CEIL}) begin
            sum_run = SUM_CEIL;
            sat_run = 1'b1;
         end else begin
            sum_run = trial[SUM_W-1:0];
         end
      end
      if (p.end_of_frame) begin
         res.total_error = sum_run;
         res.max_term    = max_run;
         res.saturated   = sat_run;
         frame_results_q.push_back(res);
         clear_frame_totals();
      end else if (p.end_of_row) begin
         pos_col = '0;
         if (32'(pos_row) < FRAME_DIM - 1)
            pos_row++;
      end else if (32'(pos_col) < FRAME_DIM - 1) begin
         pos_col++;
      end
   endfunction

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------

   function automatic pixel_pair_type make_pixel(int a0, int a1, int a2, int b0, int b1, int b2,
                                                  logic eor, logic eof);
      pixel_pair_type p;
      p.a_c0 = pix_type'(a0);
      p.a_c1 = pix_type'(a1);
      p.a_c2 = pix_type'(a2);
      p.b_c0 = pix_type'(b0);
      p.b_c1 = pix_type'(b1);
      p.b_c2 = pix_type'(b2);
      p.end_of_row   = eor;
      p.end_of_frame = eof;
      return p;
   endfunction

   // byte with extra weight on the extremes
   function automatic pix_type rand_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return pix_type'($urandom);
      endcase
   endfunction

   function automatic pixel_pair_type random_pixel(logic eor, logic eof);
      pixel_pair_type p;
      p = make_pixel(rand_byte(), rand_byte(), rand_byte(),
                     rand_byte(), rand_byte(), rand_byte(), eor, eof);
      // sometimes identical pixels, zero error
      if ($urandom_range(0, 7) == 0) begin
         p.b_c0 = p.a_c0;
         p.b_c1 = p.a_c1;
         p.b_c2 = p.a_c2;
      end
      return p;
   endfunction

   function automatic int unsigned pick_position();
      case ($urandom_range(0, 9))
         0:       return 13'($urandom);
         1:       return 4095;
         default: return $urandom_range(0, 8);
      endcase
   endfunction

   function automatic int unsigned pick_span();
      case ($urandom_range(0, 9))
         0:       return 13'($urandom);
         1:       return 0;
         2:       return 4096;
         3:       return 8191;
         default: return $urandom_range(1, 10);
      endcase
   endfunction

   function automatic int unsigned pick_weight();
      case ($urandom_range(0, 7))
         0:       return 0;
         1:       return 4095;
         2:       return 256;
         3:       return 13'($urandom);
         default: return $urandom_range(0, 4095);
      endcase
   endfunction

   task automatic drive_req(input pixel_pair_type p);
      req_if.a_c0         = p.a_c0;
      req_if.a_c1         = p.a_c1;
      req_if.a_c2         = p.a_c2;
      req_if.b_c0         = p.b_c0;
      req_if.b_c1         = p.b_c1;
      req_if.b_c2         = p.b_c2;
      req_if.end_of_row   = p.end_of_row;
      req_if.end_of_frame = p.end_of_frame;
   endtask

   // register write on the configuration port, only while the block is idle
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = CSR_DATA_W'(value);
      @(negedge clock);
      csr_we = 1'b0;
      apply_reg(idx, CSR_DATA_W'(value));
   endtask

   task automatic write_window(input int unsigned x, input int unsigned y,
                               input int unsigned w, input int unsigned h);
      write_reg(CSR_WIN_X, x);
      write_reg(CSR_WIN_Y, y);
      write_reg(CSR_WIN_W, w);
      write_reg(CSR_WIN_H, h);
   endtask

   task automatic write_weights(input int unsigned w0, input int unsigned w1,
                                input int unsigned w2);
      write_reg(CSR_WEIGHT_C0, w0);
      write_reg(CSR_WEIGHT_C1, w1);
      write_reg(CSR_WEIGHT_C2, w2);
   endtask

   // offer one beat; bursts of random length are separated by random gaps unless
   // the sender is steady, and valid stays high from one beat to the next inside a burst
   task automatic send_pixel(input pixel_pair_type p);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = sender_steady ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_if.valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      drive_req(p);
      req_if.valid = 1'b1;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      accumulate_beat(p);
      beats_sent++;
   endtask

   // well formed raster of random content
   task automatic send_frame(input int rows, input int cols);
      for (int r = 0; r < rows; r++)
         for (int c = 0; c < cols; c++)
            send_pixel(random_pixel(c == cols - 1, r == rows - 1 && c == cols - 1));
   endtask

   // stop offering, let every owed result come back, then let the pipe empty
   task automatic wait_idle();
      @(negedge clock);
      req_if.valid = 1'b0;
      burst_left   = 0;
      while (frame_results_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // register values after reset: mono, window over the whole image
   task automatic test_reset_values();
      send_pixel(make_pixel(0, 17, 200, 255, 3, 9, 1'b0, 1'b0));
      send_pixel(make_pixel(255, 0, 0, 0, 255, 255, 1'b1, 1'b0));
      send_pixel(make_pixel(128, 1, 2, 128, 3, 4, 1'b0, 1'b0));
      // frame end also ending the row
      send_pixel(make_pixel(1, 99, 99, 0, 0, 0, 1'b1, 1'b1));
      wait_idle();
   endtask

   // weighted rgb at the weight and byte extremes, then weights ignored in mono
   task automatic test_rgb_extremes();
      write_reg(CSR_MODE, MODE_RGB);
      write_weights(4095, 4095, 4095);
      // largest possible term
      send_pixel(make_pixel(255, 255, 255, 0, 0, 0, 1'b0, 1'b0));
      send_pixel(make_pixel(0, 0, 0, 255, 255, 255, 1'b0, 1'b1));
      wait_idle();
      write_weights(0, 256, 4095);
      send_pixel(make_pixel(10, 200, 7, 250, 3, 7, 1'b1, 1'b0));
      send_pixel(make_pixel(255, 0, 128, 0, 255, 127, 1'b0, 1'b1));
      wait_idle();
      write_reg(CSR_MODE, MODE_MONO);
      send_pixel(make_pixel(37, 0, 255, 200, 255, 0, 1'b0, 1'b1));
      wait_idle();
   endtask

   // inner window, empty window, and a window from the last column onward
   task automatic test_window_edges();
      write_window(1, 1, 2, 1);
      send_frame(3, 4);
      wait_idle();
      write_window(0, 0, 0, 4096);
      send_frame(1, 2);
      wait_idle();
      write_window(4095, 0, 8191, 8191);
      send_frame(2, 1);
      wait_idle();
   endtask

   // registers changed with a frame half done, new values apply to the rest
   task automatic test_midframe_write();
      write_reg(CSR_MODE, MODE_RGB);
      write_window(0, 0, 4096, 4096);
      write_weights(300, 5, 4095);
      send_pixel(random_pixel(1'b0, 1'b0));
      send_pixel(random_pixel(1'b0, 1'b0));
      send_pixel(random_pixel(1'b1, 1'b0));
      send_pixel(random_pixel(1'b0, 1'b0));
      send_pixel(random_pixel(1'b0, 1'b0));
      // nothing owed here, the pause only lets the pipe empty
      wait_idle();
      write_reg(CSR_MODE, MODE_MONO);
      write_reg(CSR_WIN_X, 1);
      send_pixel(random_pixel(1'b0, 1'b0));
      send_pixel(random_pixel(1'b1, 1'b0));
      send_pixel(random_pixel(1'b0, 1'b1));
      wait_idle();
   endtask

   // result channel held off while one beat frames keep coming: the pipe fills
   // and the request channel must stall
   task automatic test_backpressure();
      write_window(0, 0, 4096, 4096);
      stall_kind    = STALL_NONE;
      sender_steady = 1'b1;
      hold_requests++;
      repeat (40) send_pixel(random_pixel(1'b1, 1'b1));
      wait_idle();
      sender_steady = 1'b0;
   endtask

   // irregular rows and stray frame ends
   task automatic send_ragged_frame();
      int n;
      n = $urandom_range(1, 30);
      for (int i = 0; i < n; i++)
         send_pixel(random_pixel($urandom_range(0, 3) == 0,
                                 i == n - 1 || $urandom_range(0, 19) == 0));
   endtask

   task automatic program_random_config();
      write_reg(CSR_MODE, $urandom_range(0, 1));
      write_window(pick_position(), pick_position(), pick_span(), pick_span());
      write_weights(pick_weight(), pick_weight(), pick_weight());
   endtask

   // random phases: new settings, a few frames, then everything drained
   task automatic test_random_frames();
      int start_beats;
      int frames;
      start_beats = beats_sent;
      while (beats_sent - start_beats < RANDOM_BEATS) begin
         program_random_config();
         sender_steady = ($urandom_range(0, 3) == 0);
         stall_kind    = stall_kind_type'($urandom_range(0, 2));
         frames        = $urandom_range(1, 4);
         repeat (frames) begin
            if ($urandom_range(0, 4) == 0)
               send_ragged_frame();
            else
               send_frame($urandom_range(1, 6), $urandom_range(1, 10));
         end
         wait_idle();
      end
   endtask

   // ---------------------------------------------------------------
   // result side
   // ---------------------------------------------------------------

   // ready pattern of the receiver, with long hold-offs on request
   always @(negedge clock) begin
      stall_tick++;
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready = 1'b0;
      end else if (hold_requests != hold_served) begin
         hold_served  = hold_requests;
         hold_left    = HOLD_CYCLES - 1;
         rsp_if.ready = 1'b0;
      end else begin
         case (stall_kind)
            STALL_NONE:   rsp_if.ready = 1'b1;
            STALL_RANDOM: rsp_if.ready = ($urandom_range(0, 3) != 0);
            default:      rsp_if.ready = (stall_tick % 11) < 6;
         endcase
      end
   end

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         fail_count++;
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      end
   endfunction

   // each result beat against the oldest owed frame result
   always @(posedge clock) begin
      frame_result_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (frame_results_q.size() == 0) begin
            fail_count++;
            $error("result beat with no frame result owed");
         end else begin
            want = frame_results_q.pop_front();
            check_field("total_error", 64'(want.total_error), 64'(rsp_if.total_error));
            check_field("max_term", 64'(want.max_term), 64'(rsp_if.max_term));
            check_field("saturated", 64'(want.saturated), 64'(rsp_if.saturated));
         end
      end
   end

   // watchdog: too long without any beat on either channel
   always @(posedge clock) begin
      if (reset || (req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------

   initial begin
      clock        = 1'b0;
      reset        = 1'b1;
      csr_we       = 1'b0;
      csr_index    = CSR_MODE;
      csr_wdata    = '0;
      req_if.valid = 1'b0;
      rsp_if.ready = 1'b0;
      drive_req(make_pixel(0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
      reset_shadow();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_values();
      test_rgb_extremes();
      test_window_edges();
      test_midframe_write();
      test_backpressure();
      test_random_frames();
      wait_idle();

      if (frame_results_q.size() != 0) begin
         fail_count++;
         $error("%0d frame results never arrived", frame_results_q.size());
      end
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
